@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the light gate speed meter, clocked on clk and
// disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/lgsm_pkg.sv @@
// ---------------------------------------------------------------------------
// lgsm_pkg
// Widths, register codes, reset values and shared types of the light gate
// speed meter.
// ---------------------------------------------------------------------------
`default_nettype none

package lgsm_pkg;

	// tick counter width
	localparam int COUNT_WIDTH = 24;

	// field widths
	localparam int DIST_W     = 10;
	localparam int SPD_CFG_W  = 17;
	localparam int TOL_W      = 7;
	localparam int TIME_W     = 24;
	localparam int SPEED_W    = 30;
	localparam int PHASE_W    = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// comparisons between counter and time registers
	localparam int CMP_W = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;

	// band check widths
	localparam int PCT_W   = 8;
	localparam int S100_W  = SPEED_W + PCT_W;
	localparam int BOUND_W = SPD_CFG_W + PCT_W;

	// divider
	localparam int DIV_STEPS = SPEED_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam int USEC_PER_SEC = 1000000;
	localparam int PCT_FULL     = 100;

	// register reset values
	localparam logic [DIST_W-1:0]    RST_DISTANCE = DIST_W'(60);
	localparam logic [SPD_CFG_W-1:0] RST_TARGET   = SPD_CFG_W'(5000);
	localparam logic [TOL_W-1:0]     RST_TOL      = TOL_W'(10);
	localparam logic [SPD_CFG_W-1:0] RST_MIN      = SPD_CFG_W'(500);
	localparam logic [TIME_W-1:0]    RST_TIMEOUT  = TIME_W'(2000000);
	localparam logic [TIME_W-1:0]    RST_HOLD     = TIME_W'(5000000);

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE   = 2'd0,
		PH_TIMING = 2'd1,
		PH_HOLD   = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DISTANCE = 3'd0,
		CFG_TARGET   = 3'd1,
		CFG_TOL      = 3'd2,
		CFG_MIN      = 3'd3,
		CFG_TIMEOUT  = 3'd4,
		CFG_HOLD     = 3'd5
	} cfg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clear_hold;
		logic start_timing;
		logic to_idle;
		logic div_load;
		logic div_step;
		logic tol_load;
		logic latch;
		logic out_load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		phase_t phase;
		logic   gate1;
		logic   hold_done;
		logic   meas_hit;
		logic   timed_out;
		logic   below_min;
	} dp_status_t;

	// saturating tick counter increment
	function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
		return (c == CNT_MAX) ? c : c + COUNT_WIDTH'(1);
	endfunction

endpackage

`default_nettype wire

@@ rtl/lgsm_if.sv @@
// ---------------------------------------------------------------------------
// lgsm_if
// Valid/ready channels of the light gate speed meter: gate ticks in,
// measurement results out, register writes in.
// ---------------------------------------------------------------------------
`default_nettype none

// gate edge ticks
interface lgsm_in_if ();
	logic valid;
	logic ready;
	logic gate1_rise;
	logic gate2_rise;

	modport source (output valid, gate1_rise, gate2_rise, input ready);
	modport sink (input valid, gate1_rise, gate2_rise, output ready);
endinterface

// per-tick results
interface lgsm_out_if import lgsm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] speed_mm_s;
	logic               speed_error;
	logic               new_result;
	logic [PHASE_W-1:0] busy_res;

	modport source (output valid, speed_mm_s, speed_error, new_result, busy_res, input ready);
	modport sink (input valid, speed_mm_s, speed_error, new_result, busy_res, output ready);
endinterface

// register writes
interface lgsm_cfg_if import lgsm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/light_gate_speed_meter_unit.sv @@
// ---------------------------------------------------------------------------
// light_gate_speed_meter_unit
// Light gate speed meter: times gate1 to gate2 ticks, divides the gate
// distance by the elapsed time, checks the tolerance band and holds a result.
// ---------------------------------------------------------------------------
//
//   channel   direction   transaction
//   gates     in          one microsecond tick with gate1/gate2 edge flags
//   result    out         speed, error flag, new result flag, phase
//   cfg       in          register write, index and data
//
// a tick without a finished measurement passes through accept, evaluate and post
// a tick that ends a measurement also runs the 30-step restoring divider,
// then the band products and the decision, before its post
// the output register lets a new tick be accepted while a result waits;
// a result that is still not taken stalls the following tick in its post cycle
// reset restores the register defaults and idles the phase, no clearing pass
//
`default_nettype none

module light_gate_speed_meter_unit import lgsm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	lgsm_in_if.sink   gates,
	lgsm_out_if.source result,
	lgsm_cfg_if.sink  cfg
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// writes are always taken
	assign cfg.ready = 1'b1;

	// sequencer
	lgsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (gates.valid),
		.in_ready  (gates.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	lgsm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.gate1_rise  (gates.gate1_rise),
		.gate2_rise  (gates.gate2_rise),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.cmd         (cmd),
		.status      (status),
		.speed_mm_s  (result.speed_mm_s),
		.speed_error (result.speed_error),
		.new_result  (result.new_result),
		.busy_res    (result.busy_res)
	);

endmodule

`default_nettype wire

@@ rtl/lgsm_ctrl.sv @@
// ---------------------------------------------------------------------------
// lgsm_ctrl
// Sequencer for one tick: accept, evaluate phase, run the divider and band
// check when a measurement ends, then post the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lgsm_ctrl import lgsm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_TOL,
		S_DEC,
		S_POST
	} state_t;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	state_t               state_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// commands from state and status
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_EVAL: begin
				case (status.phase)
					PH_HOLD: cmd.clear_hold = status.hold_done;
					PH_TIMING: begin
						cmd.div_load = status.meas_hit;
						cmd.to_idle  = !status.meas_hit && status.timed_out;
					end
					default: cmd.start_timing = status.gate1;
				endcase
			end
			S_DIV: cmd.div_step = 1'b1;
			S_TOL: cmd.tol_load = 1'b1;
			S_DEC: begin
				cmd.to_idle = status.below_min;
				cmd.latch   = !status.below_min;
			end
			S_POST: cmd.out_load = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	// state, divider step count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid set when posting, cleared once taken
			if (state_q == S_POST && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					div_cnt_q <= '0;
					if (status.phase == PH_TIMING && status.meas_hit)
						state_q <= S_DIV;
					else
						state_q <= S_POST;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_LAST)
						state_q <= S_TOL;
				end
				S_TOL: state_q <= S_DEC;
				S_DEC: state_q <= S_POST;
				S_POST: begin
					if (!out_valid_q || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_accept_eval, in_valid && in_ready, state_q == S_EVAL)
	`ASSERT_IMPL(a_load_free, cmd.out_load, !out_valid_q || out_ready)
	`ASSERT_NEXT(a_div_end, state_q == S_DIV && div_cnt_q == DIV_LAST, state_q == S_TOL)

endmodule

`default_nettype wire

@@ rtl/lgsm_dp.sv @@
// ---------------------------------------------------------------------------
// lgsm_dp
// Registers, tick counters, restoring divider, tolerance band check and
// output register of the light gate speed meter.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lgsm_dp import lgsm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  gate1_rise,
	input  wire logic                  gate2_rise,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire ctrl_cmd_t             cmd,
	output dp_status_t                 status,
	output logic [SPEED_W-1:0]         speed_mm_s,
	output logic                       speed_error,
	output logic                       new_result,
	output logic [PHASE_W-1:0]         busy_res
);

	// configuration registers
	logic [DIST_W-1:0]    distance_q;
	logic [SPD_CFG_W-1:0] target_q;
	logic [TOL_W-1:0]     tol_q;
	logic [SPD_CFG_W-1:0] min_q;
	logic [TIME_W-1:0]    timeout_q;
	logic [TIME_W-1:0]    hold_us_q;

	// measurement state
	phase_t               phase_q;
	logic [COUNT_WIDTH-1:0] elapsed_q;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic [SPEED_W-1:0]   latched_speed_q;
	logic                 latched_error_q;
	logic                 fresh_q;
	logic                 gate1_q;
	logic                 gate2_q;

	// divider and band check
	logic [SPEED_W-1:0]     quo_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [S100_W-1:0]      s100_q;
	logic [BOUND_W-1:0]     lo_q;
	logic [BOUND_W-1:0]     hi_q;

	// output register
	logic [SPEED_W-1:0] out_speed_q;
	logic               out_error_q;
	logic               out_fresh_q;
	logic [PHASE_W-1:0] out_phase_q;

	logic [SPEED_W-1:0]     dividend;
	logic [COUNT_WIDTH:0]   div_sh;
	logic [COUNT_WIDTH:0]   div_dvs;
	logic                   div_ge;
	logic [PCT_W-1:0]       lo_pct;
	logic [PCT_W-1:0]       hi_pct;
	logic                   out_band;

	// dividend and one restoring step
	assign dividend = SPEED_W'(distance_q) * SPEED_W'(USEC_PER_SEC);
	assign div_sh   = {rem_q, quo_q[SPEED_W-1]};
	assign div_dvs  = {1'b0, elapsed_q};
	assign div_ge   = (div_sh >= div_dvs);

	// tolerance percentages
	assign lo_pct = (PCT_W'(tol_q) >= PCT_W'(PCT_FULL)) ? '0 : PCT_W'(PCT_FULL) - PCT_W'(tol_q);
	assign hi_pct = PCT_W'(PCT_FULL) + PCT_W'(tol_q);
	assign out_band = (BOUND_W'(s100_q) < lo_q && s100_q < S100_W'(lo_q))
		|| (s100_q > S100_W'(hi_q));

	// status to the controller
	always_comb begin
		status.phase     = phase_q;
		status.gate1     = gate1_q;
		status.hold_done = (CMP_W'(hold_q) >= CMP_W'(hold_us_q)) || (hold_q == CNT_MAX);
		status.meas_hit  = gate2_q && (CMP_W'(elapsed_q) <= CMP_W'(timeout_q));
		status.timed_out = (CMP_W'(elapsed_q) >= CMP_W'(timeout_q)) || (elapsed_q == CNT_MAX);
		status.below_min = (quo_q < SPEED_W'(min_q));
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_q <= RST_DISTANCE;
			target_q   <= RST_TARGET;
			tol_q      <= RST_TOL;
			min_q      <= RST_MIN;
			timeout_q  <= RST_TIMEOUT;
			hold_us_q  <= RST_HOLD;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DISTANCE: distance_q <= cfg_data[DIST_W-1:0];
				CFG_TARGET:   target_q   <= cfg_data[SPD_CFG_W-1:0];
				CFG_TOL:      tol_q      <= cfg_data[TOL_W-1:0];
				CFG_MIN:      min_q      <= cfg_data[SPD_CFG_W-1:0];
				CFG_TIMEOUT:  timeout_q  <= cfg_data[TIME_W-1:0];
				CFG_HOLD:     hold_us_q  <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// phase, counters and latched result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			elapsed_q       <= '0;
			hold_q          <= '0;
			latched_speed_q <= '0;
			latched_error_q <= 1'b0;
			fresh_q         <= 1'b0;
		end else begin
			if (cmd.capture) begin
				fresh_q <= 1'b0;
				if (phase_q == PH_HOLD)
					hold_q <= count_up(hold_q);
				else if (phase_q == PH_TIMING)
					elapsed_q <= count_up(elapsed_q);
			end
			if (cmd.clear_hold) begin
				latched_speed_q <= '0;
				latched_error_q <= 1'b0;
				hold_q          <= '0;
				elapsed_q       <= '0;
				phase_q         <= PH_IDLE;
			end
			if (cmd.start_timing) begin
				elapsed_q <= '0;
				phase_q   <= PH_TIMING;
			end
			if (cmd.to_idle)
				phase_q <= PH_IDLE;
			if (cmd.latch) begin
				latched_speed_q <= quo_q;
				latched_error_q <= out_band;
				hold_q          <= '0;
				fresh_q         <= 1'b1;
				phase_q         <= PH_HOLD;
			end
		end
	end

	// tick flags, divider, band products and output register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gate1_q <= gate1_rise;
			gate2_q <= gate2_rise;
		end
		if (cmd.div_load) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? COUNT_WIDTH'(div_sh - div_dvs) : div_sh[COUNT_WIDTH-1:0];
			quo_q <= {quo_q[SPEED_W-2:0], div_ge};
		end
		if (cmd.tol_load) begin
			s100_q <= S100_W'(quo_q) * S100_W'(PCT_FULL);
			lo_q   <= BOUND_W'(target_q) * BOUND_W'(lo_pct);
			hi_q   <= BOUND_W'(target_q) * BOUND_W'(hi_pct);
		end
		if (cmd.out_load) begin
			out_speed_q <= latched_speed_q;
			out_error_q <= latched_error_q;
			out_fresh_q <= fresh_q;
			out_phase_q <= phase_q;
		end
	end

	assign speed_mm_s  = out_speed_q;
	assign speed_error = out_error_q;
	assign new_result  = out_fresh_q;
	assign busy_res    = out_phase_q;

	`ASSERT_NEXT(a_latch_hold, cmd.latch, phase_q == PH_HOLD && latched_speed_q == $past(quo_q))
	`ASSERT_NEXT(a_hold_clear, cmd.clear_hold, phase_q == PH_IDLE && latched_speed_q == '0 && !latched_error_q)

endmodule

`default_nettype wire
